// ===== hdl/aim_bearing_elevation_distance_assert.svh =====
// Assertion macros for the aim solver block.
// Used by aim_bearing_elevation_distance.sv; expects clk_i and rst_ni in scope.
`ifndef AIM_BEARING_ELEVATION_DISTANCE_ASSERT_SVH
`define AIM_BEARING_ELEVATION_DISTANCE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ABED_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("aim solver assertion failed");

// Next-cycle implication, disabled during reset
`define ABED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("aim solver assertion failed");

`endif

// ===== hdl/abed_pkg.sv =====
// Shared types, constants and the arctangent table of the aim solver.
// No dependencies; imported by every module of the block except abed_sqrt_cell.
`timescale 1ns / 1ps

package abed_pkg;

  // Working widths
  localparam int unsigned AW = 58;  // atan2 operand width
  localparam int unsigned NW = 60;  // normalizer width
  localparam int unsigned CW = 45;  // CORDIC x/y width
  localparam int unsigned ZW = 32;  // angle accumulator width, 2^-20 degree

  // Operands are normalized so that max(|x|,|y|) lies in [2^40, 2^41)
  localparam int unsigned NORM_TOP = 41;

  // Angles in 2^-20 degree
  localparam logic signed [ZW-1:0] ANG_90  = 32'sd94371840;
  localparam logic signed [ZW-1:0] ANG_180 = 32'sd188743680;
  localparam logic signed [ZW-1:0] ROUND_Q = 32'sd4096;
  localparam int unsigned Q_SHIFT = 13;

  // Angles in 1/128 degree
  localparam int TURN_Q      = 46080;
  localparam int HALF_TURN_Q = 23040;
  localparam int ELEV_MAX_Q  = 11520;
  // 2^31 mod TURN_Q, undoes the offset that makes yaw unsigned
  localparam int YAW_OFFSET_Q = 17408;

  typedef struct packed {
    logic signed [NW-1:0] x;
    logic signed [NW-1:0] y;
    logic [NW-1:0]        m;
    logic                 zero;
  } norm_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  // round(atan(2^-k) * 2^20) in degrees
  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] k);
    case (k)
      5'd0:  return 32'sd47185920;
      5'd1:  return 32'sd27855475;
      5'd2:  return 32'sd14718068;
      5'd3:  return 32'sd7471121;
      5'd4:  return 32'sd3750058;
      5'd5:  return 32'sd1876857;
      5'd6:  return 32'sd938658;
      5'd7:  return 32'sd469357;
      5'd8:  return 32'sd234682;
      5'd9:  return 32'sd117342;
      5'd10: return 32'sd58671;
      5'd11: return 32'sd29335;
      5'd12: return 32'sd14668;
      5'd13: return 32'sd7334;
      5'd14: return 32'sd3667;
      5'd15: return 32'sd1833;
      5'd16: return 32'sd917;
      5'd17: return 32'sd458;
      5'd18: return 32'sd229;
      5'd19: return 32'sd115;
      5'd20: return 32'sd57;
      5'd21: return 32'sd29;
      5'd22: return 32'sd14;
      5'd23: return 32'sd7;
      5'd24: return 32'sd4;
      5'd25: return 32'sd2;
      5'd26: return 32'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

// ===== hdl/abed_sqrt_cell.sv =====
// One cell of the pipelined integer square root: resolves one root bit.
// No package dependencies.
`timescale 1ns / 1ps

module abed_sqrt_cell #(
  parameter int unsigned RW = 33
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RW:0]     rem_i,
  input  logic [RW-1:0]   root_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW:0]     rem_o,
  output logic [RW-1:0]   root_o,
  output logic [2*RW-1:0] rad_o
);

  logic [RW+2:0]   cat;
  logic [RW+2:0]   trial;
  logic            ge;
  logic [RW+2:0]   diff;
  logic [RW:0]     rem_d, rem_q;
  logic [RW-1:0]   root_d, root_q;
  logic [2*RW-1:0] rad_d, rad_q;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    cat    = {rem_i, rad_i[2*RW-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = (cat >= trial);
    diff   = cat - trial;
    rem_d  = ge ? diff[RW:0] : cat[RW:0];
    root_d = {root_i[RW-2:0], ge};
    rad_d  = {rad_i[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;

endmodule

// ===== hdl/abed_norm_cell.sv =====
// One step of the operand normalizer: a conditional shift by a fixed amount.
// Depends on abed_pkg (norm_t, NW, NORM_TOP).
`timescale 1ns / 1ps

module abed_norm_cell import abed_pkg::*; #(
  parameter int unsigned SHIFT = 1,
  parameter bit          RIGHT = 1'b0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  norm_t op_i,
  output norm_t op_o
);

  // right: shift when at least SHIFT more steps are needed to get below 2^NORM_TOP
  localparam int unsigned LIM_POS = RIGHT ? NORM_TOP - 1 + SHIFT : NORM_TOP - SHIFT;
  localparam logic [NW-1:0] LIM = NW'(1) << LIM_POS;

  logic  hit;
  norm_t op_d, op_q;

  // right steps shrink a too large magnitude, left steps grow a small one
  always_comb begin
    hit  = RIGHT ? (op_i.m >= LIM) : (op_i.m < LIM);
    op_d = op_i;
    if (hit) begin
      if (RIGHT) begin
        op_d.x = op_i.x >>> SHIFT;
        op_d.y = op_i.y >>> SHIFT;
        op_d.m = op_i.m >> SHIFT;
      end else begin
        op_d.x = op_i.x <<< SHIFT;
        op_d.y = op_i.y <<< SHIFT;
        op_d.m = op_i.m << SHIFT;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

// ===== hdl/abed_cordic_cell.sv =====
// One vectoring CORDIC micro-rotation with a fixed stage index.
// Depends on abed_pkg (cordic_t, atan_lut).
`timescale 1ns / 1ps

module abed_cordic_cell import abed_pkg::*; #(
  parameter int unsigned IDX = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t op_i,
  output cordic_t op_o
);

  localparam int unsigned K = IDX % 32;
  localparam logic signed [ZW-1:0] ATAN_K = atan_lut(5'(K));

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  cordic_t op_d, op_q;

  // rotate toward y = 0
  always_comb begin
    xs   = op_i.x >>> K;
    ys   = op_i.y >>> K;
    op_d = op_i;
    if (op_i.y[CW-1]) begin
      op_d.x = op_i.x - ys;
      op_d.y = op_i.y + xs;
      op_d.z = op_i.z - ATAN_K;
    end else begin
      op_d.x = op_i.x + ys;
      op_d.y = op_i.y - xs;
      op_d.z = op_i.z + ATAN_K;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q <= op_d;
    end
  end

  assign op_o = op_q;

endmodule

// ===== hdl/abed_atan2.sv =====
// Pipelined atan2: normalizer cells, quadrant fix, CORDIC cells.
// Depends on abed_pkg, abed_norm_cell and abed_cordic_cell.
`timescale 1ns / 1ps

module abed_atan2 import abed_pkg::*; #(
  parameter int unsigned STAGES = 16
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] x_i,
  input  logic signed [AW-1:0] y_i,
  output logic signed [ZW-1:0] z_o
);

  localparam int unsigned NSTEPS = 11;  // five right, six left

  logic signed [NW-1:0] xe, ye, ax, ay;
  norm_t   nrm [NSTEPS+1];
  norm_t   ent_d;
  cordic_t crd [STAGES+1];
  cordic_t fix_d;
  logic signed [ZW-1:0] z_q;

  // entry: sign extend, magnitude bound, coincident flag
  always_comb begin
    xe         = NW'(x_i);
    ye         = NW'(y_i);
    ax         = xe[NW-1] ? -xe : xe;
    ay         = ye[NW-1] ? -ye : ye;
    ent_d.x    = xe;
    ent_d.y    = ye;
    ent_d.m    = (ax > ay) ? ax : ay;
    ent_d.zero = (x_i == '0) && (y_i == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm[0] <= ent_d;
    end
  end

  // normalizer chain
  for (genvar g = 0; g < NSTEPS; g++) begin : g_norm
    localparam bit          IS_RIGHT = (g < 5);
    localparam int unsigned SH = IS_RIGHT ? (16 >> g) : (32 >> (g - 5));
    abed_norm_cell #(.SHIFT(SH), .RIGHT(IS_RIGHT)) u_norm (
      .clk_i (clk_i),
      .en_i  (en_i),
      .op_i  (nrm[g]),
      .op_o  (nrm[g+1])
    );
  end

  // left half plane: start at +-180 degrees and mirror
  always_comb begin
    fix_d.x    = nrm[NSTEPS].x[CW-1:0];
    fix_d.y    = nrm[NSTEPS].y[CW-1:0];
    fix_d.z    = '0;
    fix_d.zero = nrm[NSTEPS].zero;
    if (fix_d.x[CW-1]) begin
      fix_d.z = fix_d.y[CW-1] ? -ANG_180 : ANG_180;
      fix_d.x = -nrm[NSTEPS].x[CW-1:0];
      fix_d.y = -nrm[NSTEPS].y[CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crd[0] <= fix_d;
    end
  end

  // CORDIC chain
  for (genvar g = 0; g < STAGES; g++) begin : g_cordic
    abed_cordic_cell #(.IDX(g)) u_cordic (
      .clk_i (clk_i),
      .en_i  (en_i),
      .op_i  (crd[g]),
      .op_o  (crd[g+1])
    );
  end

  // coincident operands give angle zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q <= crd[STAGES].zero ? '0 : crd[STAGES].z;
    end
  end

  assign z_o = z_q;

endmodule

// ===== hdl/aim_bearing_elevation_distance.sv =====
// Aim solver: distance, yaw difference and pitch difference of a target.
//
// Input channel: in_valid_i / in_stall_o carry one beat of viewer and target
// coordinates (signed, 8 fraction bits), current yaw and current pitch
// (1/128 degree). Output channel: out_valid_o / out_stall_i carry one beat
// of distance, yaw difference and pitch difference per input beat, in order.
// A beat moves at a rising edge with valid high and stall low.
//
// Throughput: one beat per cycle while the skid register is empty. The path
// from the accepting edge to out_valid_o runs through the difference, square
// and sum stages, the 57-cell horizontal square root, the elevation atan2
// (one entry stage, 11 normalizer cells, a quadrant stage, the CORDIC cells,
// an exit stage), the pitch stage and the output register.
//
// Reset clears all valid bits; no beat is in flight afterwards.
// When the receiver stalls, the output register holds its beat and one
// more beat lands in a skid register; in_stall_o then rises and the whole
// pipeline holds until the skid register drains.
//
// Depends on abed_pkg, abed_sqrt_cell, abed_atan2 and the assertion macros.
`timescale 1ns / 1ps
`include "aim_bearing_elevation_distance_assert.svh"

module aim_bearing_elevation_distance import abed_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] viewer_x_i,
  input  logic signed [31:0] viewer_y_i,
  input  logic signed [31:0] viewer_z_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic signed [31:0] target_z_i,
  input  logic signed [31:0] current_yaw_i,
  input  logic signed [14:0] current_pitch_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [32:0]        distance_o,
  output logic signed [15:0] yaw_difference_o,
  output logic signed [15:0] pitch_difference_o
);

  // stage numbers of the pipeline
  localparam int unsigned DW    = 33;              // distance root width
  localparam int unsigned HW    = 57;              // horizontal root width
  localparam int unsigned LAT_A = 14 + CORDIC_STAGES;
  localparam int unsigned Y_Z   = 1 + LAT_A;       // yaw angle ready
  localparam int unsigned E_Z   = 3 + HW + LAT_A;  // elevation angle ready
  localparam int unsigned F     = E_Z + 1;         // all results ready
  localparam int unsigned MOD_STEPS = 17;
  localparam int unsigned D_V = Y_Z - (MOD_STEPS + 1);
  localparam int unsigned D_R = F - (Y_Z + 2);
  localparam int unsigned D_D = F - (3 + DW);
  localparam int unsigned D_P = E_Z - 1;
  localparam int unsigned D_Y = 2 + HW;

  localparam logic signed [18:0] HALF_Q  = 19'(HALF_TURN_Q);
  localparam logic signed [18:0] TURN_19 = 19'(TURN_Q);
  localparam logic signed [18:0] ELEV_Q  = 19'(ELEV_MAX_Q);
  localparam logic signed [18:0] YOFF_Q  = 19'(YAW_OFFSET_Q);

  logic en;
  logic in_acc;
  logic [F-1:0] vld_q;
  logic skid_vld_q, out_vld_q;
  logic out_take;

  // global advance: the pipe holds only while the skid register is full
  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;
  assign in_acc     = in_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[F-2:0], in_acc};
    end
  end

  // stage 1: differences, yaw offset to unsigned
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [14:0] pitch_q;
  logic [31:0] ymod_q [MOD_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q       <= 33'(target_x_i) - 33'(viewer_x_i);
      dz_q       <= 33'(target_z_i) - 33'(viewer_z_i);
      dy_q       <= 33'(viewer_y_i) - 33'(target_y_i);
      pitch_q    <= current_pitch_i;
      ymod_q[0]  <= {~current_yaw_i[31], current_yaw_i[30:0]};
    end
  end

  // yaw reduction modulo one turn, one conditional subtract a cell
  for (genvar g = 0; g < MOD_STEPS; g++) begin : g_ymod
    localparam logic [31:0] STEP = 32'(TURN_Q) << (MOD_STEPS - 1 - g);
    always_ff @(posedge clk_i) begin
      if (en) begin
        ymod_q[g+1] <= (ymod_q[g] >= STEP) ? ymod_q[g] - STEP : ymod_q[g];
      end
    end
  end

  // stage 2: squares of the magnitudes
  logic [31:0] ax, ay, az;
  logic [63:0] sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;

  always_comb begin
    ax    = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
    ay    = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
    az    = dz_q[32] ? 32'(-dz_q) : dz_q[31:0];
    sqx_d = ax * ax;
    sqy_d = ay * ay;
    sqz_d = az * az;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      sqz_q <= sqz_d;
    end
  end

  // stage 3: horizontal and full sums
  logic [64:0] hsum_q;
  logic [65:0] tot_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      hsum_q <= 65'(sqx_q) + 65'(sqz_q);
      tot_q  <= 66'(sqx_q) + 66'(sqz_q) + 66'(sqy_q);
    end
  end

  // distance square root chain
  logic [DW:0]     drem  [DW+1];
  logic [DW-1:0]   droot [DW+1];
  logic [2*DW-1:0] drad  [DW+1];

  assign drem[0]  = '0;
  assign droot[0] = '0;
  assign drad[0]  = tot_q;

  for (genvar g = 0; g < DW; g++) begin : g_dsqrt
    abed_sqrt_cell #(.RW(DW)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (drem[g]),
      .root_i (droot[g]),
      .rad_i  (drad[g]),
      .rem_o  (drem[g+1]),
      .root_o (droot[g+1]),
      .rad_o  (drad[g+1])
    );
  end

  // horizontal distance root with 24 extra fraction bits
  logic [HW:0]     hrem  [HW+1];
  logic [HW-1:0]   hroot [HW+1];
  logic [2*HW-1:0] hrad  [HW+1];

  assign hrem[0]  = '0;
  assign hroot[0] = '0;
  assign hrad[0]  = {1'b0, hsum_q, 48'd0};

  for (genvar g = 0; g < HW; g++) begin : g_hsqrt
    abed_sqrt_cell #(.RW(HW)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (hrem[g]),
      .root_i (hroot[g]),
      .rad_i  (hrad[g]),
      .rem_o  (hrem[g+1]),
      .root_o (hroot[g+1]),
      .rad_o  (hrad[g+1])
    );
  end

  // delay lines that line side data up with the long paths
  logic [15:0]        vred_dl  [D_V];
  logic [32:0]        dy_dl    [D_Y];
  logic [14:0]        pitch_dl [D_P];
  logic [DW-1:0]      dist_dl  [D_D];
  logic signed [15:0] yawr_dl  [D_R];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vred_dl[0]  <= ymod_q[MOD_STEPS][15:0];
      dy_dl[0]    <= dy_q;
      pitch_dl[0] <= pitch_q;
      dist_dl[0]  <= droot[DW];
      for (int i = 1; i < D_V; i++) vred_dl[i] <= vred_dl[i-1];
      for (int i = 1; i < D_Y; i++) dy_dl[i] <= dy_dl[i-1];
      for (int i = 1; i < D_P; i++) pitch_dl[i] <= pitch_dl[i-1];
      for (int i = 1; i < D_D; i++) dist_dl[i] <= dist_dl[i-1];
    end
  end

  // bearing: atan2(dz, dx)
  logic signed [ZW-1:0] zyaw, zelev;

  abed_atan2 #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (AW'(dx_q)),
    .y_i   (AW'(dz_q)),
    .z_o   (zyaw)
  );

  // elevation: atan2(dy * 2^24, h)
  logic signed [AW-1:0] ey;
  assign ey = $signed({dy_dl[D_Y-1][32], dy_dl[D_Y-1], 24'd0});

  abed_atan2 #(.STAGES(CORDIC_STAGES)) u_elev (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   ($signed({1'b0, hroot[HW]})),
    .y_i   (ey),
    .z_o   (zelev)
  );

  // yaw post: to 1/128 degree, subtract reduced yaw, wrap
  logic signed [ZW-1:0] ya_s;
  logic signed [18:0]   yq_d, yq_q;
  logic signed [18:0]   w1, w2, w3;
  logic signed [15:0]   yawr_q;

  always_comb begin
    ya_s = zyaw - ANG_90 + ROUND_Q;
    yq_d = 19'(ya_s >>> Q_SHIFT) - $signed({3'b000, vred_dl[D_V-1]}) + YOFF_Q;
    w1   = (yq_q < -HALF_Q) ? yq_q + TURN_19 : yq_q;
    w2   = (w1 < -HALF_Q) ? w1 + TURN_19 : w1;
    w3   = (w2 >= HALF_Q) ? w2 - TURN_19 : w2;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      yq_q       <= yq_d;
      yawr_q     <= w3[15:0];
      yawr_dl[0] <= yawr_q;
      for (int i = 1; i < D_R; i++) yawr_dl[i] <= yawr_dl[i-1];
    end
  end

  // elevation post: to 1/128 degree, clamp, subtract pitch
  logic signed [ZW-1:0] ze_s;
  logic signed [18:0]   eq_w, eq_c;
  logic signed [15:0]   pd_d, pd_q;

  always_comb begin
    ze_s = zelev + ROUND_Q;
    eq_w = 19'(ze_s >>> Q_SHIFT);
    eq_c = eq_w;
    if (eq_w > ELEV_Q) begin
      eq_c = ELEV_Q;
    end else if (eq_w < -ELEV_Q) begin
      eq_c = -ELEV_Q;
    end
    pd_d = eq_c[15:0] - 16'($signed(pitch_dl[D_P-1]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q <= pd_d;
    end
  end

  // output register with one skid entry
  logic [DW-1:0]      dist_o_q, dist_s_q;
  logic signed [15:0] yaw_o_q, yaw_s_q, pd_o_q, pd_s_q;
  logic               head_vld;

  assign head_vld = vld_q[F-1];
  assign out_take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en && head_vld) begin
      if (out_vld_q && !out_take) begin
        skid_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_vld_q) begin
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && head_vld) begin
      if (out_vld_q && !out_take) begin
        dist_s_q <= dist_dl[D_D-1];
        yaw_s_q  <= yawr_dl[D_R-1];
        pd_s_q   <= pd_q;
      end else begin
        dist_o_q <= dist_dl[D_D-1];
        yaw_o_q  <= yawr_dl[D_R-1];
        pd_o_q   <= pd_q;
      end
    end else if (out_take && skid_vld_q) begin
      dist_o_q <= dist_s_q;
      yaw_o_q  <= yaw_s_q;
      pd_o_q   <= pd_s_q;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign distance_o         = dist_o_q;
  assign yaw_difference_o   = yaw_o_q;
  assign pitch_difference_o = pd_o_q;

  // checks
  `ABED_ASSERT_IMPL(a_skid_needs_out, skid_vld_q, out_vld_q)
  `ABED_ASSERT_NEXT(a_stalled_beat_to_skid, out_vld_q && out_stall_i && en && head_vld, skid_vld_q)
  `ABED_ASSERT_NEXT(a_skid_drains, skid_vld_q && !out_stall_i, out_vld_q && !skid_vld_q)
  `ABED_ASSERT_IMPL(a_yaw_wrapped, out_vld_q, (yaw_o_q >= -16'sd23040) && (yaw_o_q < 16'sd23040))

endmodule
